FILE: hw/rtl/assert_macros.svh
// Assertion helpers for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is held.
`define SRT_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error("check failed");

// Clocked check that also holds during reset.
`define SRT_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) else $error("check failed");

`endif

FILE: hw/rtl/srt_pkg.sv
package srt_pkg;

    localparam int TABLE_DEPTH   = 64;
    localparam int ADV_BYTES_MAX = 32;
    localparam int BUF_DEPTH     = ADV_BYTES_MAX + 2;
    localparam int IDX_W         = $clog2(TABLE_DEPTH);
    localparam int CNT_W         = $clog2(TABLE_DEPTH + 1);
    localparam int BUF_AW        = $clog2(BUF_DEPTH + 1);
    localparam int POS_W         = $clog2(ADV_BYTES_MAX);
    localparam int DATA_AW       = IDX_W + POS_W;
    localparam int MIN_ADV_LEN   = 13;

    localparam logic [7:0] BYTE_AD_LEN   = 8'h09;
    localparam logic [7:0] BYTE_SVC_DATA = 8'h16;
    localparam logic [7:0] BYTE_FLAG     = 8'h80;
    localparam logic [7:0] BYTE_MFG      = 8'hFF;
    localparam logic [7:0] BYTE_LEN_ALT  = 8'h0B;
    localparam logic [7:0] BYTE_TAIL     = 8'hFE;

    typedef enum logic [1:0] {
        FUNC_HEADER = 2'd0,
        FUNC_BYTE   = 2'd1,
        FUNC_READ   = 2'd2,
        FUNC_NONE   = 2'd3
    } srt_func_t;

    typedef enum logic [2:0] {
        PROTO_BEACON    = 3'd0,
        PROTO_TELEMETRY = 3'd1
    } srt_proto_t;

    typedef enum logic [1:0] {
        CFG_PROTOCOL = 2'd0,
        CFG_OFFSET   = 2'd1,
        CFG_FILTER   = 2'd2
    } srt_cfg_idx_t;

    typedef enum logic [3:0] {
        OUT_FILTERED  = 4'd0,
        OUT_INSERTED  = 4'd1,
        OUT_PRESENT   = 4'd2,
        OUT_FULL      = 4'd3,
        OUT_RESP_DONE = 4'd4,
        OUT_UNKNOWN   = 4'd5,
        OUT_RESP_LIM  = 4'd6,
        OUT_READ      = 4'd7,
        OUT_BAD_INDEX = 4'd8
    } srt_outcome_t;

    typedef struct packed {
        logic [2:0]  protocol;
        logic [4:0]  uuid_offset;
        logic [31:0] uuid_filter;
    } srt_cfg_t;

    typedef struct packed {
        logic [1:0]  func;
        logic        scan_response;
        logic [47:0] address;
        logic [4:0]  payload_len;
        logic [7:0]  byte_value;
        logic        last;
        logic [5:0]  entry_index;
        logic [4:0]  position;
        logic        from_response;
    } srt_item_t;

    typedef struct packed {
        srt_outcome_t outcome;
        logic [5:0]   table_index;
        logic [47:0]  entry_address;
        logic [4:0]   adv_length;
        logic [4:0]   resp_length;
        logic [7:0]   signal;
        logic [7:0]   data_byte;
    } srt_result_t;

    // Fixed-position bytes of the current report, zero when not received
    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        logic [7:0] b10;
        logic [7:0] b11;
    } srt_fixed_t;

    typedef struct packed {
        logic              clear;
        logic [BUF_AW-1:0] raddr;
    } srt_buf_req_t;

endpackage

FILE: hw/rtl/srt_rbuf.sv
module srt_rbuf import srt_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_en,
    input  logic [7:0]        wr_byte,
    input  logic              hdr_clear,
    input  srt_buf_req_t      req,
    output logic [7:0]        rdata,
    output srt_fixed_t        fixed
);

    logic [7:0]        buf_mem [BUF_DEPTH];
    logic [7:0]        rd_reg;
    logic              rd_ok_reg;
    logic [BUF_AW-1:0] fill_reg;
    logic [7:0]        cap_reg [6];
    logic              room;

    assign room = (fill_reg < BUF_AW'(BUF_DEPTH));

    // Track fill; bytes at or above it read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else if (hdr_clear || req.clear) begin
            fill_reg <= '0;
        end else if (wr_en && room) begin
            fill_reg <= fill_reg + BUF_AW'(1);
        end
    end

    // Store the byte and keep copies of the fixed-position pattern bytes
    always_ff @(posedge aclk) begin
        if (wr_en && room) begin
            buf_mem[fill_reg] <= wr_byte;
            if (fill_reg == BUF_AW'(0))  cap_reg[0] <= wr_byte;
            if (fill_reg == BUF_AW'(1))  cap_reg[1] <= wr_byte;
            if (fill_reg == BUF_AW'(2))  cap_reg[2] <= wr_byte;
            if (fill_reg == BUF_AW'(3))  cap_reg[3] <= wr_byte;
            if (fill_reg == BUF_AW'(10)) cap_reg[4] <= wr_byte;
            if (fill_reg == BUF_AW'(11)) cap_reg[5] <= wr_byte;
        end
        rd_reg    <= buf_mem[req.raddr < BUF_AW'(BUF_DEPTH) ? req.raddr : '0];
        rd_ok_reg <= (req.raddr < fill_reg);
    end

    assign rdata     = rd_ok_reg ? rd_reg : 8'h00;
    assign fixed.b0  = (fill_reg > BUF_AW'(0))  ? cap_reg[0] : 8'h00;
    assign fixed.b1  = (fill_reg > BUF_AW'(1))  ? cap_reg[1] : 8'h00;
    assign fixed.b2  = (fill_reg > BUF_AW'(2))  ? cap_reg[2] : 8'h00;
    assign fixed.b3  = (fill_reg > BUF_AW'(3))  ? cap_reg[3] : 8'h00;
    assign fixed.b10 = (fill_reg > BUF_AW'(10)) ? cap_reg[4] : 8'h00;
    assign fixed.b11 = (fill_reg > BUF_AW'(11)) ? cap_reg[5] : 8'h00;

endmodule

FILE: hw/rtl/srt_core.sv
`include "assert_macros.svh"

module srt_core import srt_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  srt_cfg_t          cfg,
    input  logic              start,
    input  srt_item_t         item,
    output logic              idle,
    output srt_buf_req_t      buf_req,
    input  logic [7:0]        buf_rdata,
    input  srt_fixed_t        fixed,
    output logic              res_valid,
    input  logic              res_ready,
    output srt_result_t       res
);

    typedef enum logic [4:0] {
        S_IDLE, S_START, S_FILT_RD, S_FILT_CMP, S_CHECK, S_LK_RD, S_LK_CMP,
        S_AFTER, S_SH_RD, S_SH_WR, S_INS, S_CP_RD, S_CP_WR, S_SG1, S_SG2,
        S_SG3, S_T0, S_T1, S_RESP2, S_RD1, S_RD2, S_RD3, S_DONE
    } state_t;

    state_t            state_reg;
    logic              hdr_resp_reg;
    logic [47:0]       hdr_addr_reg;
    logic [4:0]        hdr_len_reg;
    logic [CNT_W-1:0]  entry_count_reg;
    logic [CNT_W-1:0]  resp_count_reg;
    logic [CNT_W-1:0]  k_reg;
    logic [CNT_W-1:0]  below_reg;
    logic              match_reg;
    logic              found_reg;
    logic [IDX_W-1:0]  pos_reg;
    logic [IDX_W-1:0]  slot_reg;
    logic [BUF_AW-1:0] n_reg;
    logic [POS_W-1:0]  rpos_reg;
    logic              rfrom_reg;
    logic              is_report_reg;
    srt_result_t       res_reg;

    // Sorted table: address in the upper bits, storage slot in the lower
    logic [47+IDX_W:0] tbl_mem [TABLE_DEPTH];
    logic [47+IDX_W:0] tbl_rdata_reg;
    logic [4:0]        adv_len_mem  [TABLE_DEPTH];
    logic [4:0]        resp_len_mem [TABLE_DEPTH];
    logic [7:0]        sig_mem      [TABLE_DEPTH];
    logic [7:0]        adv_data_mem  [TABLE_DEPTH*ADV_BYTES_MAX];
    logic [7:0]        resp_data_mem [TABLE_DEPTH*ADV_BYTES_MAX];
    logic [4:0]        adv_len_rd_reg, resp_len_rd_reg;
    logic [7:0]        sig_rd_reg, adv_data_rd_reg, resp_data_rd_reg;

    logic              tbl_ren, tbl_we;
    logic [IDX_W-1:0]  tbl_raddr, tbl_waddr;
    logic [47+IDX_W:0] tbl_wdata;
    logic              data_we;
    logic [DATA_AW-1:0] data_waddr;
    logic [7:0]        data_wdata;
    logic              sig_we;
    logic [7:0]        sig_wdata;
    logic              resp_ok;
    logic [7:0]        filt_byte;
    logic [IDX_W-1:0]  rd_slot;

    assign idle      = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;
    assign filt_byte = cfg.uuid_filter[{k_reg[1:0], 3'b000} +: 8];
    assign rd_slot   = tbl_rdata_reg[IDX_W-1:0];

    // Response pattern check on the fixed bytes
    always_comb begin
        unique case (cfg.protocol)
            PROTO_BEACON:
                resp_ok = (fixed.b0 == BYTE_AD_LEN) && (fixed.b1 == BYTE_SVC_DATA) &&
                          (fixed.b2 == BYTE_FLAG);
            PROTO_TELEMETRY:
                resp_ok = ((fixed.b0 == BYTE_AD_LEN) && (fixed.b1 == BYTE_MFG)) ||
                          ((fixed.b0 == BYTE_LEN_ALT) && (fixed.b1 == BYTE_MFG) &&
                           (fixed.b2 == BYTE_MFG) && (fixed.b3 == BYTE_TAIL));
            default:
                resp_ok = 1'b0;
        endcase
    end

    // Memory port control per state
    always_comb begin
        buf_req.clear = 1'b0;
        buf_req.raddr = '0;
        tbl_ren       = 1'b0;
        tbl_raddr     = k_reg[IDX_W-1:0];
        tbl_we        = 1'b0;
        tbl_waddr     = k_reg[IDX_W-1:0];
        tbl_wdata     = tbl_rdata_reg;
        data_we       = 1'b0;
        data_waddr    = {slot_reg, k_reg[POS_W-1:0]};
        data_wdata    = buf_rdata;
        sig_we        = 1'b0;
        sig_wdata     = buf_rdata;
        unique case (state_reg)
            S_FILT_RD: buf_req.raddr = BUF_AW'(cfg.uuid_offset) + BUF_AW'(k_reg[1:0]);
            S_CP_RD:   buf_req.raddr = k_reg[BUF_AW-1:0];
            S_SG1:     buf_req.raddr = n_reg;
            S_SG2: begin
                buf_req.raddr = n_reg + BUF_AW'(1);
                sig_we        = (buf_rdata >= BYTE_FLAG);
            end
            S_SG3:     sig_we = 1'b1;
            S_LK_RD:   tbl_ren = 1'b1;
            S_SH_RD: begin
                tbl_ren   = 1'b1;
                tbl_raddr = k_reg[IDX_W-1:0] - IDX_W'(1);
            end
            S_SH_WR:   tbl_we = 1'b1;
            S_INS: begin
                tbl_we    = 1'b1;
                tbl_waddr = pos_reg;
                tbl_wdata = {hdr_addr_reg, entry_count_reg[IDX_W-1:0]};
            end
            S_CP_WR:   data_we = 1'b1;
            S_T0: begin
                data_we    = 1'b1;
                data_waddr = {slot_reg, POS_W'(0)};
                data_wdata = (fixed.b0 == BYTE_AD_LEN) ? BYTE_MFG : fixed.b10;
            end
            S_T1: begin
                data_we    = 1'b1;
                data_waddr = {slot_reg, POS_W'(1)};
                data_wdata = (fixed.b0 == BYTE_AD_LEN) ? BYTE_MFG : fixed.b11;
            end
            S_RD1: begin
                tbl_ren   = 1'b1;
                tbl_raddr = res_reg.table_index;
            end
            S_DONE:    buf_req.clear = res_ready && is_report_reg;
            default: ;
        endcase
    end

    // Table and per-slot memories
    always_ff @(posedge aclk) begin
        if (tbl_we) tbl_mem[tbl_waddr] <= tbl_wdata;
        if (tbl_ren) tbl_rdata_reg <= tbl_mem[tbl_raddr];
        if (state_reg == S_INS) begin
            adv_len_mem[entry_count_reg[IDX_W-1:0]]  <= hdr_len_reg;
            resp_len_mem[entry_count_reg[IDX_W-1:0]] <= 5'd0;
        end
        if (state_reg == S_RESP2) resp_len_mem[slot_reg] <= n_reg[4:0];
        if (sig_we) sig_mem[slot_reg] <= sig_wdata;
        if (data_we && hdr_resp_reg) resp_data_mem[data_waddr] <= data_wdata;
        if (data_we && !hdr_resp_reg) adv_data_mem[data_waddr] <= data_wdata;
        if (state_reg == S_RD2) begin
            adv_len_rd_reg   <= adv_len_mem[rd_slot];
            resp_len_rd_reg  <= resp_len_mem[rd_slot];
            sig_rd_reg       <= sig_mem[rd_slot];
            adv_data_rd_reg  <= adv_data_mem[{rd_slot, rpos_reg}];
            resp_data_rd_reg <= resp_data_mem[{rd_slot, rpos_reg}];
        end
    end

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            hdr_resp_reg    <= 1'b0;
            hdr_addr_reg    <= '0;
            hdr_len_reg     <= '0;
            entry_count_reg <= '0;
            resp_count_reg  <= '0;
            is_report_reg   <= 1'b0;
            res_reg         <= '0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (start) begin
                        priority case (item.func)
                            FUNC_HEADER: begin
                                hdr_resp_reg <= item.scan_response;
                                hdr_addr_reg <= item.address;
                                hdr_len_reg  <= item.payload_len;
                            end
                            FUNC_BYTE: begin
                                if (item.last) begin
                                    is_report_reg <= 1'b1;
                                    state_reg     <= S_START;
                                end
                            end
                            FUNC_READ: begin
                                is_report_reg       <= 1'b0;
                                rpos_reg            <= item.position;
                                rfrom_reg           <= item.from_response;
                                res_reg.table_index <= item.entry_index;
                                if (CNT_W'(item.entry_index) >= entry_count_reg) begin
                                    res_reg.outcome <= OUT_BAD_INDEX;
                                    state_reg       <= S_DONE;
                                end else begin
                                    state_reg <= S_RD1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_START: begin
                    k_reg     <= '0;
                    below_reg <= '0;
                    found_reg <= 1'b0;
                    match_reg <= 1'b1;
                    if (hdr_resp_reg) begin
                        if (resp_ok) begin
                            state_reg <= S_LK_RD;
                        end else begin
                            res_reg.outcome <= OUT_FILTERED;
                            state_reg       <= S_DONE;
                        end
                    end else begin
                        state_reg <= S_FILT_RD;
                    end
                end
                S_FILT_RD: state_reg <= S_FILT_CMP;
                S_FILT_CMP: begin
                    if (buf_rdata != filt_byte) match_reg <= 1'b0;
                    k_reg <= k_reg + CNT_W'(1);
                    state_reg <= (k_reg[1:0] == 2'd3) ? S_CHECK : S_FILT_RD;
                end
                S_CHECK: begin
                    k_reg <= '0;
                    if (!match_reg || hdr_len_reg <= 5'(MIN_ADV_LEN)) begin
                        res_reg.outcome <= OUT_FILTERED;
                        state_reg       <= S_DONE;
                    end else begin
                        state_reg <= S_LK_RD;
                    end
                end
                // Linear search: stop on a matching address, else count smaller addresses for the insert point
                S_LK_RD: state_reg <= (k_reg >= entry_count_reg) ? S_AFTER : S_LK_CMP;
                S_LK_CMP: begin
                    if (tbl_rdata_reg[47+IDX_W:IDX_W] == hdr_addr_reg) begin
                        found_reg <= 1'b1;
                        pos_reg   <= k_reg[IDX_W-1:0];
                        slot_reg  <= rd_slot;
                        state_reg <= S_AFTER;
                    end else begin
                        if (tbl_rdata_reg[47+IDX_W:IDX_W] < hdr_addr_reg)
                            below_reg <= below_reg + CNT_W'(1);
                        k_reg     <= k_reg + CNT_W'(1);
                        state_reg <= S_LK_RD;
                    end
                end
                S_AFTER: begin
                    if (hdr_resp_reg) begin
                        if (!found_reg) begin
                            res_reg.outcome <= OUT_UNKNOWN;
                            state_reg       <= S_DONE;
                        end else if (resp_count_reg >= CNT_W'(TABLE_DEPTH)) begin
                            res_reg.outcome     <= OUT_RESP_LIM;
                            res_reg.table_index <= pos_reg;
                            state_reg           <= S_DONE;
                        end else begin
                            resp_count_reg <= resp_count_reg + CNT_W'(1);
                            n_reg          <= BUF_AW'(hdr_len_reg);
                            k_reg          <= '0;
                            state_reg <= (cfg.protocol == PROTO_BEACON) ? S_CP_RD : S_T0;
                        end
                    end else if (found_reg) begin
                        res_reg.outcome     <= OUT_PRESENT;
                        res_reg.table_index <= pos_reg;
                        state_reg           <= S_DONE;
                    end else if (entry_count_reg >= CNT_W'(TABLE_DEPTH)) begin
                        res_reg.outcome <= OUT_FULL;
                        state_reg       <= S_DONE;
                    end else begin
                        pos_reg   <= below_reg[IDX_W-1:0];
                        k_reg     <= entry_count_reg;
                        state_reg <= S_SH_RD;
                    end
                end
                // Shift entries above the insert point up by one
                S_SH_RD: state_reg <= (k_reg[IDX_W-1:0] == pos_reg) ? S_INS : S_SH_WR;
                S_SH_WR: begin
                    k_reg     <= k_reg - CNT_W'(1);
                    state_reg <= S_SH_RD;
                end
                S_INS: begin
                    slot_reg  <= entry_count_reg[IDX_W-1:0];
                    n_reg     <= BUF_AW'(hdr_len_reg);
                    k_reg     <= '0;
                    state_reg <= S_CP_RD;
                end
                S_CP_RD: begin
                    if (k_reg[BUF_AW-1:0] >= n_reg)
                        state_reg <= hdr_resp_reg ? S_RESP2 : S_SG1;
                    else
                        state_reg <= S_CP_WR;
                end
                S_CP_WR: begin
                    k_reg     <= k_reg + CNT_W'(1);
                    state_reg <= S_CP_RD;
                end
                S_SG1: state_reg <= S_SG2;
                S_SG2: begin
                    if (buf_rdata >= BYTE_FLAG) begin
                        entry_count_reg     <= entry_count_reg + CNT_W'(1);
                        res_reg.outcome     <= OUT_INSERTED;
                        res_reg.table_index <= pos_reg;
                        state_reg           <= S_DONE;
                    end else begin
                        state_reg <= S_SG3;
                    end
                end
                S_SG3: begin
                    entry_count_reg     <= entry_count_reg + CNT_W'(1);
                    res_reg.outcome     <= OUT_INSERTED;
                    res_reg.table_index <= pos_reg;
                    state_reg           <= S_DONE;
                end
                S_T0: state_reg <= S_T1;
                S_T1: state_reg <= S_RESP2;
                S_RESP2: begin
                    res_reg.outcome     <= OUT_RESP_DONE;
                    res_reg.table_index <= pos_reg;
                    state_reg           <= S_DONE;
                end
                S_RD1: state_reg <= S_RD2;
                S_RD2: state_reg <= S_RD3;
                S_RD3: begin
                    res_reg.outcome       <= OUT_READ;
                    res_reg.entry_address <= tbl_rdata_reg[47+IDX_W:IDX_W];
                    res_reg.adv_length    <= adv_len_rd_reg;
                    res_reg.resp_length   <= resp_len_rd_reg;
                    res_reg.signal        <= sig_rd_reg;
                    res_reg.data_byte     <= rfrom_reg ? resp_data_rd_reg : adv_data_rd_reg;
                    state_reg             <= S_DONE;
                end
                // Hand off the result, then clear it for the next item
                S_DONE: begin
                    if (res_ready) begin
                        res_reg   <= '0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `SRT_ASSERT(a_entry_bound, entry_count_reg <= CNT_W'(TABLE_DEPTH))
    `SRT_ASSERT(a_resp_bound, resp_count_reg <= CNT_W'(TABLE_DEPTH))
    `SRT_ASSERT(a_entry_step, entry_count_reg != $past(entry_count_reg) |-> entry_count_reg == $past(entry_count_reg) + CNT_W'(1))
    `SRT_ASSERT(a_no_start_busy, start |-> state_reg == S_IDLE)

endmodule

FILE: hw/rtl/ble_scan_report_sorted_table_unit.sv
// Scan report table.
// Input channel s_*: one item per transfer; s_tuser selects header, payload
// byte or table read; s_tlast marks the final payload byte of a report.
// Output channel m_*: one result for each final byte and each read; headers
// and non-final bytes give no result. Config channel cfg_*: always ready,
// cfg_index picks protocol, uuid offset or uuid filter.
// Items are taken only while the core is idle, so a new item waits until the
// last one is through. A read of a bad index goes straight to its result; a
// good read fetches the entry. An advertising report goes through the uuid
// filter and length check, a scan response through the pattern check; then
// the stored entries are searched. An insert shifts the entries above the
// insert point and copies the data bytes; a scan response copies its bytes
// (beacon) or writes two bytes (telemetry). The table memory is single-port.
// Results are held in an output register; while a result waits there,
// headers and bytes are still taken, and an item with a result stalls in its
// last cycle until the register frees.
// Reset clears the entry and response counts, the header and the buffer
// fill; no memory clearing pass is needed.
module ble_scan_report_sorted_table_unit import srt_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // scan_response[0], address[48:1], payload_len[53:49], byte_value[61:54],
    // entry_index[67:62], position[72:68], from_response[73], zero[79:74]
    input  logic [79:0] s_tdata,
    // func[1:0]
    input  logic [1:0]  s_tuser,
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    // table_index[5:0], entry_address[53:6], adv_length[58:54],
    // resp_length[63:59], signal[71:64], data_byte[79:72]
    output logic [79:0] m_tdata,
    // outcome[3:0]
    output logic [3:0]  m_tuser,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    srt_cfg_t     cfg_reg;
    srt_item_t    item;
    logic         start, core_idle, res_valid, res_ready;
    srt_result_t  core_res, m_res_reg;
    logic         m_valid_reg;
    srt_buf_req_t buf_req;
    logic [7:0]   buf_rdata;
    srt_fixed_t   fixed;

    assign cfg_ready = 1'b1;
    assign s_tready  = core_idle;
    assign start     = s_tvalid && s_tready;

    // Unpack the input transfer
    always_comb begin
        item.func          = s_tuser;
        item.scan_response = s_tdata[0];
        item.address       = s_tdata[48:1];
        item.payload_len   = s_tdata[53:49];
        item.byte_value    = s_tdata[61:54];
        item.last          = s_tlast;
        item.entry_index   = s_tdata[67:62];
        item.position      = s_tdata[72:68];
        item.from_response = s_tdata[73];
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            priority case (cfg_index)
                CFG_PROTOCOL: cfg_reg.protocol    <= cfg_data[2:0];
                CFG_OFFSET:   cfg_reg.uuid_offset <= cfg_data[4:0];
                CFG_FILTER:   cfg_reg.uuid_filter <= cfg_data;
                default: ;
            endcase
        end
    end

    srt_rbuf u_rbuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (start && item.func == FUNC_BYTE),
        .wr_byte   (item.byte_value),
        .hdr_clear (start && item.func == FUNC_HEADER),
        .req       (buf_req),
        .rdata     (buf_rdata),
        .fixed     (fixed)
    );

    srt_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .start     (start),
        .item      (item),
        .idle      (core_idle),
        .buf_req   (buf_req),
        .buf_rdata (buf_rdata),
        .fixed     (fixed),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (core_res)
    );

    // Output register
    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
        if (res_ready && res_valid) m_res_reg <= core_res;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_res_reg.outcome;
    assign m_tdata  = {m_res_reg.data_byte, m_res_reg.signal, m_res_reg.resp_length,
                       m_res_reg.adv_length, m_res_reg.entry_address,
                       m_res_reg.table_index};

endmodule
